// ===== rtl/qte_pkg.sv =====
// Shared types and constants of the charge/time event builder.
// Word type codes, field widths and the decoded-word struct; no dependencies.
package qte_pkg;

  // Field widths of input words and output records
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned CHARGE_W = 12;
  localparam int unsigned TIME_W  = 21;
  localparam int unsigned CEVN_W  = 24;
  localparam int unsigned TEVN_W  = 22;
  localparam int unsigned MISC_W  = 16;

  // Charge converter word types, bits 26..24
  localparam logic [2:0] CT_DATA   = 3'd0;
  localparam logic [2:0] CT_HEADER = 3'd2;
  localparam logic [2:0] CT_EOB    = 3'd4;
  localparam logic [2:0] CT_FILLER = 3'd6;

  // Time converter word types, bits 31..27
  localparam logic [4:0] TT_DATA    = 5'h00;
  localparam logic [4:0] TT_ERROR   = 5'h04;
  localparam logic [4:0] TT_GHEADER = 5'h08;
  localparam logic [4:0] TT_TRAILER = 5'h10;
  localparam logic [4:0] TT_DUMMY   = 5'h18;

  // Saturation value of the mismatch counter
  localparam logic [MISC_W-1:0] MIS_MAX = '1;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } qte_state_e;

  // One readout word, decoded
  typedef struct packed {
    logic                charge_data;
    logic                charge_evn_we;
    logic                time_data;
    logic                time_evn_we;
    logic                error;
    logic                close;
    logic [CHAN_W-1:0]   ch;
    logic [CHARGE_W-1:0] charge;
    logic [TIME_W-1:0]   hit_time;
    logic [CEVN_W-1:0]   charge_evn;
    logic [TEVN_W-1:0]   time_evn;
  } qte_dec_t;

endpackage

// ===== rtl/qte_in_if.sv =====
// Input channel of the event builder: source-tagged readout words.
// Uses qte_pkg for the word width.
interface qte_in_if import qte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] word;

  modport source (output valid, output func, output word, input ready);
  modport sink (input valid, input func, input word, output ready);
endinterface

// ===== rtl/qte_out_if.sv =====
// Output channel of the event builder: one record per channel or per mismatch.
// Uses qte_pkg for the field widths.
interface qte_out_if import qte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel;
  logic [CHARGE_W-1:0] charge;
  logic                charge_valid;
  logic [TIME_W-1:0]   hit_time;
  logic                time_valid;
  logic                multi_hit;
  logic [CEVN_W-1:0]   event_number;
  logic                ids_match;
  logic                error_seen;
  logic [MISC_W-1:0]   mismatch_count;
  logic                last;

  modport source (output valid, output channel, output charge, output charge_valid,
                  output hit_time, output time_valid, output multi_hit,
                  output event_number, output ids_match, output error_seen,
                  output mismatch_count, output last, input ready);
  modport sink (input valid, input channel, input charge, input charge_valid,
                input hit_time, input time_valid, input multi_hit,
                input event_number, input ids_match, input error_seen,
                input mismatch_count, input last, output ready);
endinterface

// ===== rtl/qte_decode.sv =====
// Readout word decoder: splits a charge or time word into its fields and actions.
// Uses qte_pkg for type codes and the decoded-word struct.
module qte_decode import qte_pkg::*; (
  input  logic              func_i,
  input  logic [WORD_W-1:0] word_i,
  output qte_dec_t          dec_o
);

  logic [2:0] ctype;
  logic [4:0] ttype;

  assign ctype = word_i[26:24];
  assign ttype = word_i[31:27];

  // Decode type code of the tagged converter
  always_comb begin
    dec_o            = '0;
    dec_o.charge     = word_i[CHARGE_W-1:0];
    dec_o.hit_time   = word_i[TIME_W-1:0];
    dec_o.charge_evn = word_i[CEVN_W-1:0];
    dec_o.time_evn   = word_i[26:5];
    if (!func_i) begin
      dec_o.ch = word_i[20:17];
      unique case (ctype) inside
        CT_EOB:               dec_o.charge_evn_we = 1'b1;
        CT_HEADER, CT_FILLER: ;
        CT_DATA:              dec_o.charge_data = 1'b1;
        default:              dec_o.error = 1'b1;
      endcase
    end else begin
      dec_o.ch = word_i[24:21];
      unique case (ttype) inside
        TT_GHEADER:           dec_o.time_evn_we = 1'b1;
        TT_DATA:              dec_o.time_data = 1'b1;
        TT_ERROR:             dec_o.error = 1'b1;
        TT_TRAILER, TT_DUMMY: dec_o.close = 1'b1;
        default:              ;
      endcase
    end
  end

endmodule

// ===== rtl/qte_mem.sv =====
// Per-channel value store: one write port, one read port with registered data.
// No package dependency.
module qte_mem #(
  parameter int unsigned W     = 12,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/qte_tdc_event_builder_placeholder.sv =====
// Channel presence tracker: charge, time and multi-hit flags per channel.
// Imports qte_pkg, though no item of it is used.
module qte_flags import qte_pkg::*; #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                set_charge_i,
  input  logic                hit_i,
  input  logic [IDX_W-1:0]    widx_i,
  input  logic                clear_i,
  input  logic [IDX_W-1:0]    ridx_i,
  output logic                time_seen_o,
  output logic [2:0]          rflags_o
);

  logic [CHANNELS-1:0] cp_q, cp_d;
  logic [CHANNELS-1:0] tp_q, tp_d;
  logic [CHANNELS-1:0] xh_q, xh_d;

  // Set presence on data words, drop everything when clear_i is raised
  always_comb begin
    cp_d = cp_q;
    tp_d = tp_q;
    xh_d = xh_q;
    if (clear_i) begin
      cp_d = '0;
      tp_d = '0;
      xh_d = '0;
    end else begin
      if (set_charge_i) begin
        cp_d[widx_i] = 1'b1;
      end
      if (hit_i) begin
        if (tp_q[widx_i]) begin
          xh_d[widx_i] = 1'b1;
        end else begin
          tp_d[widx_i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0;
      tp_q <= '0;
      xh_q <= '0;
    end else begin
      cp_q <= cp_d;
      tp_q <= tp_d;
      xh_q <= xh_d;
    end
  end

  assign time_seen_o = tp_q[widx_i];
  assign rflags_o    = {xh_q[ridx_i], tp_q[ridx_i], cp_q[ridx_i]};

endmodule

// ===== rtl/qdc_tdc_event_builder.sv =====
// Event builder for a charge converter and a time converter read out together.
// Non-closing words: one per cycle while collecting, no result. A closing word with
// matching event numbers gives CHANNELS records, each by channel memory read, record
// load and output transfer, the next read once a record is taken; a mismatch record
// is valid the cycle after the close. Input is held off during readout.
// Reset (rst_ni, asynchronous): flags, event numbers and mismatch counter cleared.
module qdc_tdc_event_builder import qte_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qte_in_if.sink    in_i,
  qte_out_if.source out_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  qte_state_e          state_q, state_d;
  qte_dec_t            dec;
  logic                acc;
  logic                ch_ok;
  logic [IDX_W-1:0]    widx;
  logic                time_seen;
  logic [2:0]          rflags;
  logic                cmem_we, tmem_we;
  logic [CHARGE_W-1:0] cmem_rdata;
  logic [TIME_W-1:0]   tmem_rdata;
  logic                flag_clear;

  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [CEVN_W-1:0]   cevn_q, cevn_d;
  logic [TEVN_W-1:0]   tevn_q, tevn_d;
  logic                err_q, err_d;
  logic [MISC_W-1:0]   mis_q, mis_d;
  logic                ovalid_q, ovalid_d;

  logic [CHAN_W-1:0]   o_ch_q, o_ch_d;
  logic [CHARGE_W-1:0] o_charge_q, o_charge_d;
  logic                o_cv_q, o_cv_d;
  logic [TIME_W-1:0]   o_time_q, o_time_d;
  logic                o_tv_q, o_tv_d;
  logic                o_mh_q, o_mh_d;
  logic [CEVN_W-1:0]   o_evn_q, o_evn_d;
  logic                o_match_q, o_match_d;
  logic                o_err_q, o_err_d;
  logic [MISC_W-1:0]   o_mis_q, o_mis_d;
  logic                o_last_q, o_last_d;

  qte_decode u_decode (
    .func_i (in_i.func),
    .word_i (in_i.word),
    .dec_o  (dec)
  );

  assign in_i.ready = (state_q == ST_COLLECT);
  assign acc        = in_i.valid && in_i.ready;
  assign ch_ok      = ({1'b0, dec.ch} < 5'(CHANNELS));
  assign widx       = dec.ch[IDX_W-1:0];
  assign cmem_we    = acc && dec.charge_data && ch_ok;
  assign tmem_we    = acc && dec.time_data && ch_ok && !time_seen;

  qte_flags #(
    .CHANNELS (CHANNELS)
  ) u_flags (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .set_charge_i (cmem_we),
    .hit_i        (acc && dec.time_data && ch_ok),
    .widx_i       (widx),
    .clear_i      (flag_clear),
    .ridx_i       (rd_idx_q),
    .time_seen_o  (time_seen),
    .rflags_o     (rflags)
  );

  qte_mem #(
    .W     (CHARGE_W),
    .DEPTH (CHANNELS)
  ) u_charge_mem (
    .clk_i   (clk_i),
    .we_i    (cmem_we),
    .waddr_i (widx),
    .wdata_i (dec.charge),
    .raddr_i (rd_idx_q),
    .rdata_o (cmem_rdata)
  );

  qte_mem #(
    .W     (TIME_W),
    .DEPTH (CHANNELS)
  ) u_time_mem (
    .clk_i   (clk_i),
    .we_i    (tmem_we),
    .waddr_i (widx),
    .wdata_i (dec.hit_time),
    .raddr_i (rd_idx_q),
    .rdata_o (tmem_rdata)
  );

  // Next state: collect words, sweep the channel memories, hold each record
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    cevn_d     = cevn_q;
    tevn_d     = tevn_q;
    err_d      = err_q;
    mis_d      = mis_q;
    ovalid_d   = ovalid_q;
    flag_clear = 1'b0;
    o_ch_d     = o_ch_q;
    o_charge_d = o_charge_q;
    o_cv_d     = o_cv_q;
    o_time_d   = o_time_q;
    o_tv_d     = o_tv_q;
    o_mh_d     = o_mh_q;
    o_evn_d    = o_evn_q;
    o_match_d  = o_match_q;
    o_err_d    = o_err_q;
    o_mis_d    = o_mis_q;
    o_last_d   = o_last_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (acc) begin
          if (dec.charge_evn_we) cevn_d = dec.charge_evn;
          if (dec.time_evn_we)   tevn_d = dec.time_evn;
          if (dec.error)         err_d  = 1'b1;
          if (dec.close) begin
            if ({2'b00, tevn_q} == cevn_q) begin
              rd_idx_d = '0;
              state_d  = ST_READ;
            end else begin
              // Mismatch: one record with the counter after its update
              if (mis_q != MIS_MAX) mis_d = mis_q + MISC_W'(1);
              o_ch_d     = '0;
              o_charge_d = '0;
              o_cv_d     = 1'b0;
              o_time_d   = '0;
              o_tv_d     = 1'b0;
              o_mh_d     = 1'b0;
              o_evn_d    = cevn_q;
              o_match_d  = 1'b0;
              o_err_d    = err_q;
              o_mis_d    = (mis_q != MIS_MAX) ? mis_q + MISC_W'(1) : mis_q;
              o_last_d   = 1'b1;
              ovalid_d   = 1'b1;
              state_d    = ST_SEND;
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Mask stored values of channels without data this event
        o_ch_d     = CHAN_W'(rd_idx_q);
        o_charge_d = rflags[0] ? cmem_rdata : '0;
        o_cv_d     = rflags[0];
        o_time_d   = rflags[1] ? tmem_rdata : '0;
        o_tv_d     = rflags[1];
        o_mh_d     = rflags[2];
        o_evn_d    = cevn_q;
        o_match_d  = 1'b1;
        o_err_d    = err_q;
        o_mis_d    = mis_q;
        o_last_d   = (rd_idx_q == LAST_IDX);
        ovalid_d   = 1'b1;
        state_d    = ST_SEND;
      end
      ST_SEND: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          if (o_last_q) begin
            flag_clear = 1'b1;
            err_d      = 1'b0;
            state_d    = ST_COLLECT;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Control and event state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_COLLECT;
      rd_idx_q <= '0;
      cevn_q   <= '0;
      tevn_q   <= '0;
      err_q    <= 1'b0;
      mis_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      cevn_q   <= cevn_d;
      tevn_q   <= tevn_d;
      err_q    <= err_d;
      mis_q    <= mis_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output record payload
  always_ff @(posedge clk_i) begin
    o_ch_q     <= o_ch_d;
    o_charge_q <= o_charge_d;
    o_cv_q     <= o_cv_d;
    o_time_q   <= o_time_d;
    o_tv_q     <= o_tv_d;
    o_mh_q     <= o_mh_d;
    o_evn_q    <= o_evn_d;
    o_match_q  <= o_match_d;
    o_err_q    <= o_err_d;
    o_mis_q    <= o_mis_d;
    o_last_q   <= o_last_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.channel        = o_ch_q;
  assign out_o.charge         = o_charge_q;
  assign out_o.charge_valid   = o_cv_q;
  assign out_o.hit_time       = o_time_q;
  assign out_o.time_valid     = o_tv_q;
  assign out_o.multi_hit      = o_mh_q;
  assign out_o.event_number   = o_evn_q;
  assign out_o.ids_match      = o_match_q;
  assign out_o.error_seen     = o_err_q;
  assign out_o.mismatch_count = o_mis_q;
  assign out_o.last           = o_last_q;

  // Words are never taken while a record waits for its transfer
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && ovalid_q))
    else $error("input accepted while a record is pending");

  // A mismatch record is always the last of its event
  a_mismatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !o_match_q) |-> o_last_q)
    else $error("mismatch record without last");

  // The mismatch counter never goes down
  a_mis_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (mis_q >= $past(mis_q)))
    else $error("mismatch counter decreased");

  // The error flag is clear again once an event has been delivered
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && out_o.ready && o_last_q) |=> !err_q)
    else $error("error flag kept past event close");

endmodule

// ===== tb/tb_qdc_tdc_event_builder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the charge/time event builder.
// Depends on qte_pkg, qte_in_if, qte_out_if and the qdc_tdc_event_builder RTL.
module tb_qdc_tdc_event_builder;
  import qte_pkg::*;

  localparam int unsigned NUM_CH       = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS = 370;

  // One output record as the block presents it
  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [CHARGE_W-1:0] charge;
    logic                charge_valid;
    logic [TIME_W-1:0]   hit_time;
    logic                time_valid;
    logic                multi_hit;
    logic [CEVN_W-1:0]   event_number;
    logic                ids_match;
    logic                error_seen;
    logic [MISC_W-1:0]   mismatch_count;
    logic                last;
  } qte_record_t;

  // Tracks the event contents and keeps the records each close should produce
  class qte_event_predictor;
    logic [CHARGE_W-1:0] charge_q [NUM_CH];
    bit                  charge_seen [NUM_CH];
    logic [TIME_W-1:0]   first_time [NUM_CH];
    bit                  time_seen [NUM_CH];
    bit                  repeat_hit [NUM_CH];
    logic [CEVN_W-1:0]   charge_evn;
    logic [TEVN_W-1:0]   time_evn;
    bit                  error_latched;
    logic [MISC_W-1:0]   mismatch_total;
    qte_record_t         expected_records [$];
    int unsigned         fail_count;

    function new();
      clear_event();
      charge_evn     = '0;
      time_evn       = '0;
      mismatch_total = '0;
      fail_count     = 0;
    endfunction

    function void clear_event();
      for (int k = 0; k < NUM_CH; k++) begin
        charge_q[k]    = '0;
        charge_seen[k] = 1'b0;
        first_time[k]  = '0;
        time_seen[k]   = 1'b0;
        repeat_hit[k]  = 1'b0;
      end
      error_latched = 1'b0;
    endfunction

    // Build the records of a closed event, then wipe the per-event stores
    function void close_event();
      qte_record_t rec;
      if ({2'b00, time_evn} == charge_evn) begin
        for (int k = 0; k < NUM_CH; k++) begin
          rec.channel        = CHAN_W'(k);
          rec.charge         = charge_q[k];
          rec.charge_valid   = charge_seen[k];
          rec.hit_time       = first_time[k];
          rec.time_valid     = time_seen[k];
          rec.multi_hit      = repeat_hit[k];
          rec.event_number   = charge_evn;
          rec.ids_match      = 1'b1;
          rec.error_seen     = error_latched;
          rec.mismatch_count = mismatch_total;
          rec.last           = (k == NUM_CH - 1);
          expected_records.push_back(rec);
        end
      end else begin
        if (mismatch_total != MIS_MAX) mismatch_total++;
        rec                = '0;
        rec.event_number   = charge_evn;
        rec.error_seen     = error_latched;
        rec.mismatch_count = mismatch_total;
        rec.last           = 1'b1;
        expected_records.push_back(rec);
      end
      clear_event();
    endfunction

    // Decode one accepted readout word
    task note_word(logic src, logic [WORD_W-1:0] w);
      logic [CHAN_W-1:0] ch;
      if (!src) begin
        case (w[26:24])
          CT_EOB:              charge_evn = w[23:0];
          CT_HEADER, CT_FILLER: ;
          CT_DATA: begin
            ch = w[20:17];
            if (ch < NUM_CH) begin
              charge_q[ch]    = w[11:0];
              charge_seen[ch] = 1'b1;
            end
          end
          default:             error_latched = 1'b1;
        endcase
      end else begin
        case (w[31:27])
          TT_GHEADER: time_evn = w[26:5];
          TT_DATA: begin
            ch = w[24:21];
            if (ch < NUM_CH) begin
              if (!time_seen[ch]) begin
                first_time[ch] = w[20:0];
                time_seen[ch]  = 1'b1;
              end else begin
                repeat_hit[ch] = 1'b1;
              end
            end
          end
          TT_ERROR:             error_latched = 1'b1;
          TT_TRAILER, TT_DUMMY: close_event();
          default: ;
        endcase
      end
    endtask

    task report(string msg);
      fail_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want, logic [31:0] ch);
      if (got !== want)
        report($sformatf("channel %0d %s: got 0x%0h, expected 0x%0h", ch, name, got, want));
    endtask

    // Compare one transferred record with the oldest one waiting
    task check_record(qte_record_t got);
      qte_record_t want;
      if (expected_records.size() == 0) begin
        report($sformatf("record for channel %0d with nothing expected", got.channel));
      end else begin
        want = expected_records.pop_front();
        check_field("channel", got.channel, want.channel, want.channel);
        check_field("charge", got.charge, want.charge, want.channel);
        check_field("charge_valid", got.charge_valid, want.charge_valid, want.channel);
        check_field("hit_time", got.hit_time, want.hit_time, want.channel);
        check_field("time_valid", got.time_valid, want.time_valid, want.channel);
        check_field("multi_hit", got.multi_hit, want.multi_hit, want.channel);
        check_field("event_number", got.event_number, want.event_number, want.channel);
        check_field("ids_match", got.ids_match, want.ids_match, want.channel);
        check_field("error_seen", got.error_seen, want.error_seen, want.channel);
        check_field("mismatch_count", got.mismatch_count, want.mismatch_count,
                    want.channel);
        check_field("last", got.last, want.last, want.channel);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  qte_in_if  in_if ();
  qte_out_if out_if ();

  qdc_tdc_event_builder #(.CHANNELS(NUM_CH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  qte_event_predictor sb;
  qte_record_t        seen_rec;
  int unsigned        tx_idle_pct;
  int unsigned        rx_idle_pct;
  int unsigned        useful_items;
  logic               hold_req;
  logic               hold_ack = 1'b0;
  int unsigned        hold_left = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #30_000_000;
    $display("tb_qdc_tdc_event_builder NOT OK");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Sample transfers on both channels; check results before noting new input
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_if.valid && out_if.ready) begin
        seen_rec.channel        = out_if.channel;
        seen_rec.charge         = out_if.charge;
        seen_rec.charge_valid   = out_if.charge_valid;
        seen_rec.hit_time       = out_if.hit_time;
        seen_rec.time_valid     = out_if.time_valid;
        seen_rec.multi_hit      = out_if.multi_hit;
        seen_rec.event_number   = out_if.event_number;
        seen_rec.ids_match      = out_if.ids_match;
        seen_rec.error_seen     = out_if.error_seen;
        seen_rec.mismatch_count = out_if.mismatch_count;
        seen_rec.last           = out_if.last;
        sb.check_record(seen_rec);
      end
      if (in_if.valid && in_if.ready) sb.note_word(in_if.func, in_if.word);
    end
  end

  // Words the block acts on; headers, fillers and unknown time types are not counted
  function automatic bit acts_on(logic src, logic [WORD_W-1:0] w);
    if (src) return w[31:27] inside {TT_DATA, TT_ERROR, TT_GHEADER, TT_TRAILER, TT_DUMMY};
    return !(w[26:24] inside {CT_HEADER, CT_FILLER});
  endfunction

  // Offer one word after a random gap and hold it until the transfer
  task automatic send_word(input logic src, input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= src;
    in_if.word  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (acts_on(src, w)) useful_items++;
  endtask

  // One event with random content: charge and time words interleaved, then usually a close
  task automatic random_event();
    logic [WORD_W:0]     charge_part [$];
    logic [WORD_W:0]     time_part [$];
    logic [WORD_W:0]     tw;
    logic [TEVN_W-1:0]   tevn;
    logic [CEVN_W-1:0]   cevn;
    logic [CHARGE_W-1:0] value;
    logic [TIME_W-1:0]   hit;
    logic [4:0]          odd_type;
    int unsigned         pick;
    tevn = TEVN_W'($urandom);
    cevn = {2'b00, tevn};
    pick = $urandom_range(99);
    if (pick >= 90) cevn[23:22] = 2'($urandom_range(3, 1));
    else if (pick >= 75) cevn[21:0] = tevn ^ TEVN_W'($urandom_range(4194303, 1));

    // charge block
    if ($urandom_range(3) != 0)
      charge_part.push_back({1'b0, 5'($urandom), CT_HEADER, 24'($urandom)});
    repeat ($urandom_range(10)) begin
      case ($urandom_range(3))
        0:       value = '0;
        1:       value = '1;
        default: value = CHARGE_W'($urandom);
      endcase
      charge_part.push_back({1'b0, 5'($urandom), CT_DATA, 3'($urandom),
                             4'($urandom_range(15)), 5'($urandom), value});
    end
    if ($urandom_range(7) == 0)
      charge_part.push_back({1'b0, 5'($urandom), 3'($urandom_range(3) * 2 + 1),
                             24'($urandom)});
    if ($urandom_range(4) == 0)
      charge_part.push_back({1'b0, 5'($urandom), CT_FILLER, 24'($urandom)});
    if ($urandom_range(19) != 0)
      charge_part.push_back({1'b0, 5'($urandom), CT_EOB, cevn});

    // time block
    if ($urandom_range(19) != 0)
      time_part.push_back({1'b1, TT_GHEADER, tevn, 5'($urandom)});
    repeat ($urandom_range(12)) begin
      case ($urandom_range(3))
        0:       hit = '0;
        1:       hit = '1;
        default: hit = TIME_W'($urandom);
      endcase
      time_part.push_back({1'b1, TT_DATA, 2'($urandom), 4'($urandom_range(15)), hit});
    end
    if ($urandom_range(7) == 0)
      time_part.push_back({1'b1, TT_ERROR, 27'($urandom)});
    if ($urandom_range(7) == 0) begin
      odd_type = 5'($urandom);
      if (odd_type inside {TT_DATA, TT_ERROR, TT_GHEADER, TT_TRAILER, TT_DUMMY})
        odd_type = 5'h01;
      time_part.push_back({1'b1, odd_type, 27'($urandom)});
    end

    // merge the two streams in random order
    while (charge_part.size() != 0 || time_part.size() != 0) begin
      if (time_part.size() == 0 || (charge_part.size() != 0 && $urandom_range(1) == 0))
        tw = charge_part.pop_front();
      else
        tw = time_part.pop_front();
      send_word(tw[WORD_W], tw[WORD_W-1:0]);
    end

    // close, occasionally left out so the next event piles on
    if ($urandom_range(19) != 0)
      send_word(1'b1, {($urandom_range(1) != 0) ? TT_TRAILER : TT_DUMMY, 27'($urandom)});
  endtask

  // Short burst of arbitrary words
  task automatic noise_burst();
    repeat ($urandom_range(6, 1)) send_word(1'($urandom), WORD_W'($urandom));
  endtask

  // Wait for every expected record, then let the block settle
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.func   = 1'b0;
    in_if.word   = '0;
    hold_req     = 1'b0;
    tx_idle_pct  = 24;
    rx_idle_pct  = 56;
    useful_items = 0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Event with matching numbers at zero: channel and value extremes, overwrite,
    // repeated time hit, ignored words
    send_word(1'b0, {5'h00, CT_HEADER, 24'h000000});
    send_word(1'b0, {5'h00, CT_DATA, 3'h0, 4'h0, 5'h00, 12'h000});
    send_word(1'b0, {5'h1f, CT_DATA, 3'h7, 4'hf, 5'h1f, 12'hfff});
    send_word(1'b0, {5'h00, CT_DATA, 3'h0, 4'hf, 5'h00, 12'h5a5});
    send_word(1'b0, {5'h1f, CT_FILLER, 24'hffffff});
    send_word(1'b0, {5'h00, CT_EOB, 24'h000000});
    send_word(1'b1, {TT_GHEADER, 22'h000000, 5'h1f});
    send_word(1'b1, {TT_DATA, 2'b11, 4'h0, 21'h1fffff});
    send_word(1'b1, {TT_DATA, 2'b00, 4'h0, 21'h000000});
    send_word(1'b1, {TT_DATA, 2'b00, 4'hf, 21'h000000});
    send_word(1'b1, {5'h01, 27'h7ffffff});
    send_word(1'b1, {TT_TRAILER, 27'h0000000});

    // Mismatch: charge number beyond the time number's width, every invalid
    // charge type and a time error word
    send_word(1'b0, {5'h00, CT_EOB, 24'hffffff});
    send_word(1'b1, {TT_GHEADER, 22'h3fffff, 5'h00});
    send_word(1'b0, {5'h00, 3'd1, 24'h000000});
    send_word(1'b0, {5'h00, 3'd3, 24'h000000});
    send_word(1'b0, {5'h00, 3'd5, 24'h000000});
    send_word(1'b0, {5'h00, 3'd7, 24'h000000});
    send_word(1'b1, {TT_ERROR, 27'h7ffffff});
    send_word(1'b1, {TT_DUMMY, 27'h7ffffff});

    // Match at the top time number with no channel data; error flag cleared
    send_word(1'b0, {5'h00, CT_EOB, 24'h3fffff});
    send_word(1'b1, {TT_TRAILER, 27'h7ffffff});

    // Random events; hold the receiver off early so the block backs up
    useful_items = 0;
    hold_req <= ~hold_req;
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (useful_items >= RANDOM_ITEMS / 3) begin
        tx_idle_pct = 56;
        rx_idle_pct = 24;
      end
      if ($urandom_range(7) == 0) noise_burst();
      else random_event();
    end

    wait_drain();
    if (sb.fail_count == 0) $display("tb_qdc_tdc_event_builder OK");
    else $display("tb_qdc_tdc_event_builder NOT OK");
    $finish;
  end

endmodule
